// ===== design/profile_value_area_finder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the value area finder
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PROFILE_VALUE_AREA_FINDER_TOP_MACROS_SVH
`define PROFILE_VALUE_AREA_FINDER_TOP_MACROS_SVH

// same-cycle implication
`define PVAF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PVAF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pvaf_pkg.sv =====
// ----------------------------------------------------------------------------
// pvaf_pkg
// Shared widths, limits and types of the value area finder.
// ----------------------------------------------------------------------------
`default_nettype none

package pvaf_pkg;

	localparam int MAX_ROWS = 256;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int ROWS_W   = ROW_W + 1;
	localparam int CNT_W    = 9;
	localparam int TOT_W    = 17;
	localparam int TGT_W    = TOT_W + 3;   // 7 * total
	localparam int ACC10_W  = TOT_W + 4;   // 10 * band sum

	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
	localparam logic [TOT_W-1:0]  TOT_MAX    = '1;
	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(MAX_ROWS);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             occupied;
		logic             last;
	} item_t;

	typedef struct packed {
		logic             valid_res;
		logic [ROW_W-1:0] peak_row;
		logic [ROW_W-1:0] upper_edge_row;
		logic [ROW_W-1:0] lower_edge_row;
	} res_t;

endpackage

`default_nettype wire

// ===== design/pvaf_ram.sv =====
// ----------------------------------------------------------------------------
// pvaf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pvaf_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/pvaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvaf_ctrl
// Histogram update, peak scan, band growth and clearing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "profile_value_area_finder_top_macros.svh"

module pvaf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pvaf_pkg::item_t             in_item,
	input  logic [pvaf_pkg::ROWS_W-1:0] eff_rows,
	output logic                        res_vld,
	input  logic                        res_ready,
	output pvaf_pkg::res_t              res,
	output logic                        ram_we,
	output logic [pvaf_pkg::ROW_W-1:0]  ram_waddr,
	output logic [pvaf_pkg::CNT_W-1:0]  ram_wdata,
	output logic                        ram_re,
	output logic [pvaf_pkg::ROW_W-1:0]  ram_raddr,
	input  logic [pvaf_pkg::CNT_W-1:0]  ram_rdata
);

	import pvaf_pkg::*;

	localparam int IDX_W = ROW_W + 2;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_RUN    = 4'd1;
	localparam logic [3:0] ST_FLUSH  = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_SETUP  = 4'd4;
	localparam logic [3:0] ST_INIT   = 4'd5;
	localparam logic [3:0] ST_LOAD   = 4'd6;
	localparam logic [3:0] ST_DECIDE = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;

	// look-ahead slots: two rows above and two below the band
	localparam logic [1:0] SLOT_A1 = 2'd0;
	localparam logic [1:0] SLOT_A2 = 2'd1;
	localparam logic [1:0] SLOT_B1 = 2'd2;
	localparam logic [1:0] SLOT_B2 = 2'd3;

	logic [3:0]         state_q;
	logic               in_acc;
	logic               cnt_en;

	logic               ing_vld_s1;
	logic [ROW_W-1:0]   ing_row_s1;
	logic               fwd_vld_q;
	logic [ROW_W-1:0]   fwd_row_q;
	logic [CNT_W-1:0]   fwd_cnt_q;
	logic [CNT_W-1:0]   ing_base;
	logic [CNT_W-1:0]   ing_next;

	logic [TOT_W-1:0]   total_q;
	logic [TGT_W-1:0]   tgt7_q;
	logic [ROWS_W-1:0]  rows_q;
	logic [ROW_W-1:0]   clr_q;

	logic [ROWS_W-1:0]  scan_q;
	logic               scan_issue;
	logic               sc_vld_s1;
	logic [ROW_W-1:0]   sc_row_s1;
	logic [CNT_W-1:0]   best_q;
	logic [ROW_W-1:0]   peak_q;

	logic [ROW_W-1:0]   up_q;
	logic [ROW_W-1:0]   down_q;
	logic [TOT_W-1:0]   acc_q;
	logic [CNT_W-1:0]   a1_q, a2_q, b1_q, b2_q;
	logic [1:0]         init_k_q;
	logic               ld_vld_s1;
	logic [1:0]         ld_slot_s1;
	logic               ld_inr_s1;
	res_t               res_q;

	logic [ACC10_W-1:0] acc10;
	logic [CNT_W:0]     up_sum;
	logic [CNT_W:0]     down_sum;
	logic               need_more;
	logic               can_up;
	logic               can_down;
	logic               go_up;
	logic               step;

	logic               fetch;
	logic [1:0]         fslot;
	logic [IDX_W-1:0]   fidx;
	logic               f_inr;

	assign in_ready = (state_q == ST_RUN);
	assign in_acc   = in_valid && in_ready;
	assign cnt_en   = in_item.occupied && ({1'b0, in_item.row} < eff_rows);

	// read-modify-write; forward the word held in the forwarding register on a row match
	assign ing_base = (fwd_vld_q && (fwd_row_q == ing_row_s1)) ? fwd_cnt_q : ram_rdata;
	assign ing_next = (ing_base == CNT_MAX) ? ing_base : ing_base + CNT_W'(1);

	assign scan_issue = (state_q == ST_SCAN) && (scan_q != rows_q);

	// band growth decision: 10*acc < 7*total is acc < ceil(0.7*total)
	assign acc10     = {acc_q, 3'b000} + ACC10_W'({acc_q, 1'b0});
	assign need_more = acc10 < ACC10_W'(tgt7_q);
	assign can_up    = (up_q != '0);
	assign can_down  = (ROWS_W'(down_q) + ROWS_W'(1)) < rows_q;
	assign up_sum    = {1'b0, a1_q} + {1'b0, a2_q};
	assign down_sum  = {1'b0, b1_q} + {1'b0, b2_q};
	assign go_up     = !can_down || (can_up && (up_sum >= down_sum));
	assign step      = need_more && (can_up || can_down);

	always_comb begin
		fetch = 1'b0;
		fslot = SLOT_A1;
		fidx  = '0;
		if (state_q == ST_INIT) begin
			fetch = 1'b1;
			fslot = init_k_q;
			unique case (init_k_q)
				SLOT_A1: fidx = IDX_W'(up_q) - IDX_W'(1);
				SLOT_A2: fidx = IDX_W'(up_q) - IDX_W'(2);
				SLOT_B1: fidx = IDX_W'(down_q) + IDX_W'(1);
				SLOT_B2: fidx = IDX_W'(down_q) + IDX_W'(2);
			endcase
		end else if ((state_q == ST_DECIDE) && step) begin
			fetch = 1'b1;
			fslot = go_up ? SLOT_A2 : SLOT_B2;
			fidx  = go_up ? (IDX_W'(up_q) - IDX_W'(3)) : (IDX_W'(down_q) + IDX_W'(3));
		end
	end

	// rows above the top or past the grid read as zero
	assign f_inr = !fidx[IDX_W-1] && (fidx[ROWS_W-1:0] < rows_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ing_row_s1;
		ram_wdata = ing_next;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (ing_vld_s1) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = in_item.row;
		priority if (in_acc) begin
			ram_re = cnt_en;
		end else if (scan_issue) begin
			ram_re    = 1'b1;
			ram_raddr = scan_q[ROW_W-1:0];
		end else if (fetch && f_inr) begin
			ram_re    = 1'b1;
			ram_raddr = fidx[ROW_W-1:0];
		end else begin
			ram_re = 1'b0;
		end
	end

	assign res_vld = (state_q == ST_EMIT);
	assign res     = res_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			total_q    <= '0;
			ing_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
			sc_vld_s1  <= 1'b0;
			ld_vld_s1  <= 1'b0;
		end else begin
			ing_vld_s1 <= in_acc && cnt_en;
			fwd_vld_q  <= ing_vld_s1;
			sc_vld_s1  <= scan_issue;
			ld_vld_s1  <= fetch;
			if (in_acc && cnt_en && (total_q != TOT_MAX)) begin
				total_q <= total_q + TOT_W'(1);
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (in_acc && in_item.last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH:  state_q <= ST_SCAN;
				ST_SCAN: begin
					if (!scan_issue) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP:  state_q <= (best_q == '0) ? ST_EMIT : ST_INIT;
				ST_INIT: begin
					if (init_k_q == SLOT_B2) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD:   state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= step ? ST_LOAD : ST_EMIT;
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_CLEAR;
						total_q <= '0;
					end
				end
				default:   state_q <= ST_CLEAR;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ing_row_s1 <= in_item.row;
			if (in_item.last) begin
				rows_q <= eff_rows;
			end
		end
		fwd_row_q  <= ing_row_s1;
		fwd_cnt_q  <= ing_next;
		ld_slot_s1 <= fslot;
		ld_inr_s1  <= f_inr;

		if (state_q == ST_FLUSH) begin
			tgt7_q <= {total_q, 3'b000} - TGT_W'(total_q);
			scan_q <= '0;
			best_q <= '0;
			peak_q <= '0;
		end
		if (scan_issue) begin
			scan_q    <= scan_q + ROWS_W'(1);
			sc_row_s1 <= scan_q[ROW_W-1:0];
		end
		// strict compare keeps the first row on ties
		if (sc_vld_s1 && (ram_rdata > best_q)) begin
			best_q <= ram_rdata;
			peak_q <= sc_row_s1;
		end

		if (state_q == ST_SETUP) begin
			up_q     <= peak_q;
			down_q   <= peak_q;
			acc_q    <= TOT_W'(best_q);
			init_k_q <= SLOT_A1;
			res_q    <= '0;
		end
		if (state_q == ST_INIT) begin
			init_k_q <= init_k_q + 2'd1;
		end
		if (state_q == ST_DECIDE) begin
			if (step) begin
				if (go_up) begin
					up_q  <= up_q - ROW_W'(1);
					acc_q <= acc_q + TOT_W'(a1_q);
					a1_q  <= a2_q;
				end else begin
					down_q <= down_q + ROW_W'(1);
					acc_q  <= acc_q + TOT_W'(b1_q);
					b1_q   <= b2_q;
				end
			end else begin
				res_q.valid_res      <= 1'b1;
				res_q.peak_row       <= peak_q;
				res_q.upper_edge_row <= up_q;
				res_q.lower_edge_row <= down_q;
			end
		end
		if (ld_vld_s1) begin
			unique case (ld_slot_s1)
				SLOT_A1: a1_q <= ld_inr_s1 ? ram_rdata : '0;
				SLOT_A2: a2_q <= ld_inr_s1 ? ram_rdata : '0;
				SLOT_B1: b1_q <= ld_inr_s1 ? ram_rdata : '0;
				SLOT_B2: b2_q <= ld_inr_s1 ? ram_rdata : '0;
			endcase
		end
	end

	`PVAF_ASSERT_IMP(a_band_order, state_q == ST_DECIDE, (up_q <= down_q) && (ROWS_W'(down_q) < rows_q), "band edges out of order or past the grid")
	`PVAF_ASSERT_IMP(a_peak_in_band, res_vld && res.valid_res, (res.upper_edge_row <= res.peak_row) && (res.peak_row <= res.lower_edge_row), "peak row outside the band")
	`PVAF_ASSERT_IMP(a_acc_bound, state_q == ST_DECIDE, acc_q <= total_q, "band sum exceeds cell total")
	`PVAF_ASSERT_NXT(a_last_stalls, in_acc && in_item.last, !in_ready, "input not stalled after last cell")

endmodule

`default_nettype wire

// ===== design/profile_value_area_finder_top.sv =====
// Sequence: after the last cell the rows in use are scanned for the peak, the four
// look-ahead rows are loaded and the band grows one row per step, all paced by the
// single RAM read port. Throughput: one cell per cycle while a frame streams in;
// after each result all 256 rows of the histogram RAM are cleared, during which no
// cell is taken. Reset: arst_n clears control state, sets rows_in_use to 256 and
// runs the same clearing pass before the first cell is taken.
// ----------------------------------------------------------------------------
// profile_value_area_finder_top
// Streams grid cells into a per-row histogram, then reports the peak row and
// the 70 percent value band around it.
// ----------------------------------------------------------------------------
`default_nettype none

module profile_value_area_finder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// cell stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] row
	input  logic                        s_tuser,   // [0] occupied
	input  logic                        s_tlast,   // last cell of the frame
	// rows_in_use register
	input  logic                        cfg_we,
	input  logic [pvaf_pkg::ROWS_W-1:0] cfg_wdata,
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // [7:0] peak, [15:8] upper, [23:16] lower
	output logic                        m_tuser    // [0] valid_res
);

	import pvaf_pkg::*;

	logic [ROWS_W-1:0] rows_cfg_q;
	logic [ROWS_W-1:0] eff_rows;
	item_t             item;

	logic              res_vld;
	logic              res_ready;
	res_t              res;
	logic              out_vld_q;
	res_t              out_q;

	logic              ram_we;
	logic [ROW_W-1:0]  ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ROW_W-1:0]  ram_raddr;
	logic [CNT_W-1:0]  ram_rdata;

	// config register; values above the grid size clamp to it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= ROWS_RESET;
		end else if (cfg_we) begin
			rows_cfg_q <= cfg_wdata;
		end
	end

	assign eff_rows = (rows_cfg_q > ROWS_RESET) ? ROWS_RESET : rows_cfg_q;

	assign item.row      = s_tdata[ROW_W-1:0];
	assign item.occupied = s_tuser;
	assign item.last     = s_tlast;

	// per-row counts
	pvaf_ram #(
		.DEPTH (MAX_ROWS),
		.WIDTH (CNT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pvaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.eff_rows  (eff_rows),
		.res_vld   (res_vld),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// output register: one held result does not hold up the next frame's cells
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.valid_res;
	assign m_tdata  = {out_q.lower_edge_row, out_q.upper_edge_row, out_q.peak_row};

endmodule

`default_nettype wire

// ===== test/profile_value_area_finder_top_tb.sv =====
// ----------------------------------------------------------------------------
// profile_value_area_finder_top_tb
// Streams grid cells into the value area finder and checks each result
// (peak row and band edges) against a cycle-free histogram predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module profile_value_area_finder_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pvaf_pkg::*;

	// run limits
	localparam int LIMIT       = 1_000_000;  // cycles before the run is declared hung
	localparam int DRAIN       = 1100;       // worst band search plus RAM clear
	localparam int PHASE_CELLS = 70;         // random cells per register setting
	localparam int PRESSURE_AT = 20;         // result count that starts the long hold
	localparam int LONG_HOLD   = 4000;       // receiver hold-off length in cycles

	// DUT ports
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata   = '0;     // [7:0] row
	logic                s_tuser   = 1'b0;   // [0] occupied
	logic                s_tlast   = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [ROWS_W-1:0]   cfg_wdata = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [23:0]         m_tdata;            // [7:0] peak, [15:8] upper, [23:16] lower
	logic                m_tuser;            // [0] valid_res

	// predictor state: mirror of the histogram, the total and rows_in_use
	bit [CNT_W-1:0]      hist [MAX_ROWS];
	bit [TOT_W-1:0]      total = '0;
	logic [ROWS_W-1:0]   rows_cfg = ROWS_RESET;

	item_t               pending [$];        // cells waiting to be offered
	res_t                band_expect [$];    // predicted results, oldest first

	bit                  sender_idle   = 1'b1;
	bit                  receiver_idle = 1'b1;
	int                  send_gap  = 0;
	int                  recv_gap  = 0;
	int                  hold_left = 0;
	int                  results_seen = 0;
	int                  errors = 0;
	int                  cycles = 0;

	profile_value_area_finder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// rows_in_use above the histogram depth is clamped
	function automatic int grid_rows();
		return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
	endfunction

	// rows off either end of the grid read as empty
	function automatic int unsigned row_count(int r, int n);
		if (r < 0 || r >= n)
			return 0;
		return hist[r];
	endfunction

	// peak row, then widen toward the heavier two-row look-ahead until
	// the band holds ceil(0.7 * total); ties widen upward (lower index)
	function automatic res_t value_band();
		res_t        band;
		int          n, pk, up, dn;
		int unsigned best, acc, target, up_sum, dn_sum;
		bit          can_up, can_dn;
		band = '0;
		n = grid_rows();
		if (total == 0)
			return band;
		best = 0;
		pk = 0;
		for (int i = 0; i < n; i++) begin
			if (hist[i] > best) begin
				best = hist[i];
				pk = i;
			end
		end
		if (best == 0)
			return band;
		target = (7 * int'(total) + 9) / 10;
		acc = best;
		up = pk;
		dn = pk;
		while (acc < target) begin
			can_up = up > 0;
			can_dn = dn + 1 < n;
			// both grid edges reached (only possible once counts saturate)
			if (!can_up && !can_dn)
				break;
			up_sum = row_count(up - 1, n) + row_count(up - 2, n);
			dn_sum = row_count(dn + 1, n) + row_count(dn + 2, n);
			if (!can_dn || (can_up && up_sum >= dn_sum)) begin
				up--;
				acc += row_count(up, n);
			end else begin
				dn++;
				acc += row_count(dn, n);
			end
		end
		band.valid_res      = 1'b1;
		band.peak_row       = ROW_W'(pk);
		band.upper_edge_row = ROW_W'(up);
		band.lower_edge_row = ROW_W'(dn);
		return band;
	endfunction

	// one accepted cell: count it if in the grid, close the frame on last
	task automatic log_cell(input logic [7:0] row, input logic occ, input logic is_last);
		if (occ && int'(row) < grid_rows()) begin
			if (hist[row] != CNT_MAX)
				hist[row]++;
			if (total != TOT_MAX)
				total++;
		end
		if (is_last) begin
			band_expect = {band_expect, value_band()};
			foreach (hist[i])
				hist[i] = '0;
			total = '0;
		end
	endtask

	// wait cycles before the next request; idling is switched per phase
	function automatic int idle_draw(bit enabled);
		if (!enabled || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers pending cells, predicts on each accepted request
	// ------------------------------------------------------------------
	always @(posedge clk) begin : driver
		item_t cur_item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				log_cell(s_tdata, s_tuser, s_tlast);
			// free to move on once the current request is gone
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending.size() != 0) begin
					cur_item = pending.pop_front();
					s_tdata  <= cur_item.row;
					s_tuser  <= cur_item.occupied;
					s_tlast  <= cur_item.last;
					s_tvalid <= 1'b1;
					send_gap <= idle_draw(sender_idle);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random ready, one long hold-off, field-by-field compare
	// ------------------------------------------------------------------
	task automatic check_field(input string what, input int want, input logic [7:0] got);
		if (got !== 8'(want)) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : receiver
		res_t want;
		int   g, h;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_gap  <= 0;
			hold_left <= 0;
		end else begin
			g = recv_gap;
			h = hold_left;
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (band_expect.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got valid %0b data %h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = band_expect.pop_front();
					check_field("valid_res", want.valid_res, {7'b0, m_tuser});
					check_field("peak_row", want.peak_row, m_tdata[7:0]);
					check_field("upper_edge_row", want.upper_edge_row, m_tdata[15:8]);
					check_field("lower_edge_row", want.lower_edge_row, m_tdata[23:16]);
				end
				g = idle_draw(receiver_idle);
				// back up the block: results held, later frames stall the input
				if (results_seen == PRESSURE_AT)
					h = LONG_HOLD;
			end
			if (h != 0) begin
				hold_left <= h - 1;
				recv_gap  <= g;
				m_tready  <= 1'b0;
			end else if (g != 0) begin
				hold_left <= 0;
				recv_gap  <= g - 1;
				m_tready  <= 1'b0;
			end else begin
				hold_left <= 0;
				recv_gap  <= 0;
				m_tready  <= 1'b1;
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// register write, only issued while the block is idle
	task automatic set_rows(input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ROWS_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		rows_cfg   = ROWS_W'(value);
		@(negedge clk);
	endtask

	task automatic push_cell(input int row, input bit occ, input bit is_last);
		item_t c;
		c.row      = ROW_W'(row);
		c.occupied = occ;
		c.last     = is_last;
		pending = {pending, c};
	endtask

	// all requests taken, all results back, then let the band search and
	// the RAM clear finish before touching the register; sampled on the
	// falling edge so the driver's updates have landed
	task automatic settle();
		while (pending.size() != 0 || s_tvalid || band_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// one well-formed frame clustered around a random center; some cells
	// land anywhere (out of grid included), some are empty
	task automatic queue_frame(input int span, output int len);
		int center, spread, r;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
		center = $urandom_range(0, span - 1);
		spread = $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				r = $urandom_range(0, 255);
			end else begin
				r = center + $urandom_range(0, 2 * spread) - spread;
				if (r < 0)
					r = 0;
				if (r > 255)
					r = 255;
			end
			push_cell(r, $urandom_range(0, 3) != 0, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int rows, queued, len;
		foreach (hist[i])
			hist[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset
		repeat (DRAIN) @(posedge clk);

		// full grid
		set_rows(256);
		push_cell(0, 1, 1);                     // lone cell at the top row
		push_cell(128, 0, 1);                   // nothing occupied
		push_cell(255, 1, 0);                   // band spans the whole grid
		push_cell(255, 1, 0);
		push_cell(0, 1, 1);
		push_cell(10, 1, 0);                    // look-ahead tie goes up
		push_cell(10, 1, 0);
		push_cell(9, 1, 0);
		push_cell(11, 1, 1);
		push_cell(3, 1, 0);                     // peak tie takes the first row
		push_cell(8, 1, 0);
		push_cell(170, 0, 0);
		push_cell(85, 0, 1);
		settle();

		// single row: out-of-grid cells dropped, last on an empty cell
		set_rows(1);
		push_cell(0, 1, 0);
		push_cell(1, 1, 0);
		push_cell(255, 1, 0);
		push_cell(0, 0, 1);
		settle();

		// zero rows: nothing counted
		set_rows(0);
		push_cell(0, 1, 0);
		push_cell(5, 1, 1);
		settle();

		// register beyond the histogram depth is clamped
		set_rows(511);
		push_cell(255, 1, 0);
		push_cell(254, 1, 0);
		push_cell(255, 1, 1);
		settle();
		set_rows(300);
		push_cell(200, 1, 0);
		push_cell(100, 1, 1);
		settle();
		set_rows(2);
		push_cell(0, 1, 0);
		push_cell(1, 1, 0);
		push_cell(1, 1, 1);
		settle();

		// row count saturates at 511 while the total keeps going, so the
		// target cannot be met and widening stops at both edges
		set_rows(1);
		sender_idle = 1'b0;
		for (int i = 0; i < 740; i++)
			push_cell(0, 1, i == 739);
		settle();

		// random frames under a sequence of settings
		for (int k = 0; k < 8; k++) begin
			case (k)
				0:       rows = 2;
				1:       rows = 256;
				2:       rows = 1;
				3:       rows = 255;
				4:       rows = $urandom_range(257, 511);
				default: rows = $urandom_range(1, 256);
			endcase
			set_rows(rows);
			sender_idle   = (k % 3 != 1);
			receiver_idle = (k % 4 != 2);
			queued = 0;
			while (queued < PHASE_CELLS) begin
				queue_frame(grid_rows(), len);
				queued += len;
			end
			settle();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/pvaf_pkg.sv
design/pvaf_ram.sv
design/pvaf_ctrl.sv
design/profile_value_area_finder_top.sv
test/profile_value_area_finder_top_tb.sv
